/* sv/int32_shift_subtract_divider_unit_assert.svh */
// assertion macros for the shift-subtract divider
`ifndef INT32_SHIFT_SUBTRACT_DIVIDER_UNIT_ASSERT_SVH
`define INT32_SHIFT_SUBTRACT_DIVIDER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// property checked outside reset
`define ISSD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked also during reset
`define ISSD_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ISSD_ASSERT(label, prop, msg)
`define ISSD_ASSERT_RST(label, prop, msg)

`endif

`endif

/* sv/issd_pkg.sv */
// shared constants and types for the shift-subtract divider
package issd_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(DATA_WIDTH);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DATA_WIDTH - 1);

  // division modes carried on the action field
  localparam logic ACT_UNSIGNED = 1'b0;
  localparam logic ACT_SIGNED   = 1'b1;

  // control from the sequencer to the cell row
  typedef struct packed {
    logic load;
    logic step;
  } ctl_t;

endpackage

/* sv/issd_cell.sv */
// one bit slice of the divider: remainder bit, quotient bit, divisor bit
module issd_cell (
  input  logic clk,
  input  logic load,
  input  logic step,
  input  logic num_bit,
  input  logic den_bit,
  input  logic rem_in,
  input  logic q_in,
  input  logic take,
  input  logic borrow_in,
  output logic rem,
  output logic q,
  output logic borrow_out
);

  logic den;
  logic diff;

  // trial subtract on the shifted remainder bit
  assign diff       = rem_in ^ den ^ borrow_in;
  assign borrow_out = (~rem_in & den) | (~(rem_in ^ den) & borrow_in);

  // slice state: load the operands, then shift and restore each step
  always_ff @(posedge clk) begin
    if (load) begin
      rem <= 1'b0;
      q   <= num_bit;
      den <= den_bit;
    end else if (step) begin
      rem <= take ? diff : rem_in;
      q   <= q_in;
    end
  end

endmodule

/* sv/issd_array.sv */
// row of divider slices with the rippling borrow chain
module issd_array (
  input  logic                           clk,
  input  issd_pkg::ctl_t                 ctl,
  input  logic [issd_pkg::DATA_WIDTH-1:0] num,
  input  logic [issd_pkg::DATA_WIDTH-1:0] den,
  output logic [issd_pkg::DATA_WIDTH-1:0] quo
);

  import issd_pkg::*;

  logic [DATA_WIDTH-1:0] rem;
  logic [DATA_WIDTH-1:0] q;
  logic [DATA_WIDTH-1:0] borrow;
  logic [DATA_WIDTH-1:0] rem_in;
  logic [DATA_WIDTH-1:0] q_in;
  logic [DATA_WIDTH-1:0] borrow_in;
  logic                  take;

  // subtract when the shifted-out bit was set or no borrow leaves the top
  assign take = rem[DATA_WIDTH-1] | ~borrow[DATA_WIDTH-1];

  // neighbor wiring: dividend bits enter the remainder at the bottom
  assign rem_in    = {rem[DATA_WIDTH-2:0], q[DATA_WIDTH-1]};
  assign q_in      = {q[DATA_WIDTH-2:0], take};
  assign borrow_in = {borrow[DATA_WIDTH-2:0], 1'b0};

  for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
    issd_cell u_cell (
      .clk        (clk),
      .load       (ctl.load),
      .step       (ctl.step),
      .num_bit    (num[i]),
      .den_bit    (den[i]),
      .rem_in     (rem_in[i]),
      .q_in       (q_in[i]),
      .take       (take),
      .borrow_in  (borrow_in[i]),
      .rem        (rem[i]),
      .q          (q[i]),
      .borrow_out (borrow[i])
    );
  end

  assign quo = q;

endmodule

/* sv/int32_shift_subtract_divider_unit.sv */
// top level of the 32-bit shift-subtract divider
//
// Input channel: in_valid / in_stall carry action (0 unsigned, 1 signed),
// dividend and divisor. A word is taken when in_valid is high and in_stall
// is low. Output channel: out_valid / out_stall carry the quotient, truncated
// toward zero; a zero divisor gives 0, most negative by minus one wraps.
//
// One word is worked at a time. On acceptance the operands are turned into
// magnitudes and loaded into a row of 32 bit slices; the row then yields one
// quotient bit per cycle, the borrow rippling along the slices, until the
// step counter reaches its last step. In the DONE state, once the output
// register is free, the sign is applied and the result moves to the output
// register; a new word can be taken in the cycle after the result is written.
//
// The output register frees the row: a new word is accepted while the last
// quotient still waits. If the receiver stalls and a second result is ready,
// the block holds that result and keeps in_stall high until the output
// register is free. Reset (rst, synchronous) empties the block.
`include "int32_shift_subtract_divider_unit_assert.svh"

module int32_shift_subtract_divider_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            action,
  input  logic [issd_pkg::DATA_WIDTH-1:0] dividend,
  input  logic [issd_pkg::DATA_WIDTH-1:0] divisor,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [issd_pkg::DATA_WIDTH-1:0] quotient
);

  import issd_pkg::*;

  typedef enum logic [1:0] {IDLE, RUN, DONE} state_t;

  state_t                state;
  logic [CNT_W-1:0]      cnt;
  logic                  negate;
  logic                  zero;
  logic                  accept;
  logic                  out_load;
  logic                  is_signed;
  logic [DATA_WIDTH-1:0] num_mag;
  logic [DATA_WIDTH-1:0] den_mag;
  logic [DATA_WIDTH-1:0] quo;
  logic [DATA_WIDTH-1:0] quotient_next;
  ctl_t                  ctl;

  assign in_stall  = (state != IDLE);
  assign accept    = in_valid && (state == IDLE);
  assign out_load  = (state == DONE) && (!out_valid || !out_stall);
  assign is_signed = (action == ACT_SIGNED);

  // operand magnitudes in signed mode
  assign num_mag = (is_signed && dividend[DATA_WIDTH-1]) ? (~dividend + 1'b1) : dividend;
  assign den_mag = (is_signed && divisor[DATA_WIDTH-1]) ? (~divisor + 1'b1) : divisor;

  // row control
  always_comb begin
    ctl.load = accept;
    ctl.step = (state == RUN);
  end

  issd_array u_array (
    .clk (clk),
    .ctl (ctl),
    .num (num_mag),
    .den (den_mag),
    .quo (quo)
  );

  // sign fix-up and zero divisor override
  always_comb begin
    if (zero) begin
      quotient_next = '0;
    end else if (negate) begin
      quotient_next = ~quo + 1'b1;
    end else begin
      quotient_next = quo;
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      // output register: load a finished quotient, clear once taken
      if (out_load) begin
        out_valid <= 1'b1;
        quotient  <= quotient_next;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (accept) begin
            state  <= RUN;
            cnt    <= '0;
            negate <= is_signed && (dividend[DATA_WIDTH-1] ^ divisor[DATA_WIDTH-1]);
            zero   <= (divisor == '0);
          end
        end
        RUN: begin
          cnt <= cnt + 1'b1;
          if (cnt == LAST_STEP) begin
            state <= DONE;
          end
        end
        DONE: begin
          if (out_load) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  `ISSD_ASSERT(a_accept_starts_run, accept |=> (state == RUN) && (cnt == '0), "no run start")
  `ISSD_ASSERT(a_last_step_done, (state == RUN) && (cnt == LAST_STEP) |=> (state == DONE), "overrun")
  `ISSD_ASSERT(a_zero_divisor, out_load && zero |=> out_valid && (quotient == '0), "zero divisor")
  `ISSD_ASSERT(a_no_drop, (state == DONE) && out_valid && out_stall |=> (state == DONE), "dropped")
  `ISSD_ASSERT_RST(a_reset_empty, rst |=> !out_valid && (state == IDLE), "reset left the block busy")

endmodule

/* tb/int32_shift_subtract_divider_unit_chk.sv */
// quotient predictor and scoreboard for the shift-subtract divider testbench
module int32_shift_subtract_divider_unit_chk (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic                            action,
  input  logic [issd_pkg::DATA_WIDTH-1:0] dividend,
  input  logic [issd_pkg::DATA_WIDTH-1:0] divisor,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [issd_pkg::DATA_WIDTH-1:0] quotient,
  output int                              errors,
  output int                              outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import issd_pkg::*;

  // one accepted input word and the quotient it must produce
  typedef struct packed {
    logic                  action;
    logic [DATA_WIDTH-1:0] dividend;
    logic [DATA_WIDTH-1:0] divisor;
    logic [DATA_WIDTH-1:0] quotient;
  } quotient_exp_t;

  quotient_exp_t quotient_q[$];

  initial begin
    errors      = 0;
    outstanding = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    errors++;
  endtask

  // restoring division on magnitudes, sign fixed up afterwards
  function automatic logic [DATA_WIDTH-1:0] divide_word(
    input logic                  is_signed,
    input logic [DATA_WIDTH-1:0] num_in,
    input logic [DATA_WIDTH-1:0] den_in
  );
    logic [DATA_WIDTH-1:0] num;
    logic [DATA_WIDTH-1:0] den;
    logic [DATA_WIDTH-1:0] rem;
    logic [DATA_WIDTH-1:0] quo;
    logic                  flip;
    logic                  carry;
    num  = num_in;
    den  = den_in;
    rem  = '0;
    quo  = '0;
    flip = 1'b0;
    if (den == '0) return '0;
    if (is_signed) begin
      if (num[DATA_WIDTH-1]) begin
        num  = '0 - num;
        flip = ~flip;
      end
      if (den[DATA_WIDTH-1]) begin
        den  = '0 - den;
        flip = ~flip;
      end
    end
    for (int b = DATA_WIDTH - 1; b >= 0; b--) begin
      carry = rem[DATA_WIDTH-1];
      rem   = {rem[DATA_WIDTH-2:0], num[b]};
      if (carry || rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    if (flip) quo = '0 - quo;
    return quo;
  endfunction

  // results are retired before the same-edge input word is queued
  always @(posedge clk) begin : monitor
    quotient_exp_t head;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (quotient_q.size() == 0) begin
          report_mismatch($sformatf("unexpected quotient word %h", quotient));
        end else begin
          head = quotient_q.pop_front();
          if (quotient !== head.quotient)
            report_mismatch($sformatf("quotient %h expected %h (mode %0d, %h / %h)",
                                      quotient, head.quotient, head.action,
                                      head.dividend, head.divisor));
        end
      end
      if (in_valid && !in_stall) begin
        head.action   = action;
        head.dividend = dividend;
        head.divisor  = divisor;
        head.quotient = divide_word(action == ACT_SIGNED, dividend, divisor);
        quotient_q.push_back(head);
      end
    end
    outstanding <= quotient_q.size();
  end

endmodule

/* tb/int32_shift_subtract_divider_unit_tb.sv */
// stimulus, handshake pacing and verdict for the shift-subtract divider
module int32_shift_subtract_divider_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import issd_pkg::*;

  localparam int   ITEMS_PER_PHASE = 317;
  localparam int   HOLD_CYCLES     = 400;
  localparam int   DRAIN_CYCLES    = 40;
  localparam int   WATCHDOG_LIMIT  = 2000;
  localparam int   MAX_GAP         = 12;

  localparam logic [DATA_WIDTH-1:0] MOST_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic [DATA_WIDTH-1:0] MOST_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] ALL_ONES = '1;

  logic                  clk;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  logic                  action    = ACT_UNSIGNED;
  logic [DATA_WIDTH-1:0] dividend  = '0;
  logic [DATA_WIDTH-1:0] divisor   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [DATA_WIDTH-1:0] quotient;

  int errors;
  int outstanding;
  int send_idle_pct = 30;
  int recv_idle_pct = 68;
  bit hold_req      = 1'b0;
  int idle_cycles   = 0;

  int32_shift_subtract_divider_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .dividend  (dividend),
    .divisor   (divisor),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .quotient  (quotient)
  );

  int32_shift_subtract_divider_unit_chk u_chk (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .action      (action),
    .dividend    (dividend),
    .divisor     (divisor),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .quotient    (quotient),
    .errors      (errors),
    .outstanding (outstanding)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // offer one word after a random gap and hold it until taken
  task automatic send_word(
    input logic                  op,
    input logic [DATA_WIDTH-1:0] num,
    input logic [DATA_WIDTH-1:0] den
  );
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= op;
    dividend <= num;
    divisor  <= den;
    do @(posedge clk); while (in_stall);
  endtask

  // stop offering until every queued quotient has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // operand mix: full range, short values, signed extremes, small magnitudes
  function automatic logic [DATA_WIDTH-1:0] rand_operand();
    logic [DATA_WIDTH-1:0] v;
    case ($urandom_range(9))
      0, 1, 2, 3: v = $urandom;
      4, 5:       v = $urandom >> $urandom_range(DATA_WIDTH - 1);
      6: begin
        case ($urandom_range(4))
          0:       v = '0;
          1:       v = 1;
          2:       v = ALL_ONES;
          3:       v = MOST_NEG;
          default: v = MOST_POS;
        endcase
      end
      7:       v = $urandom_range(15);
      8:       v = '0 - DATA_WIDTH'($urandom_range(15));
      default: v = ~($urandom >> $urandom_range(DATA_WIDTH - 1));
    endcase
    return v;
  endfunction

  task automatic send_random(input int count, input int hold_at, input int drain_at);
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) hold_req = 1'b1;
      if (i == drain_at) wait_drained();
      send_word($urandom_range(1) ? ACT_SIGNED : ACT_UNSIGNED, rand_operand(), rand_operand());
    end
  endtask

  // receiver pacing, with one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // main sequence
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, zero divisor, wrap, short dividends, sign mixes
    send_word(ACT_UNSIGNED, '0, 1);
    send_word(ACT_UNSIGNED, ALL_ONES, 1);
    send_word(ACT_UNSIGNED, ALL_ONES, ALL_ONES);
    send_word(ACT_UNSIGNED, 7, '0);
    send_word(ACT_UNSIGNED, '0, '0);
    send_word(ACT_UNSIGNED, 5, 7);
    send_word(ACT_UNSIGNED, 100, 7);
    send_word(ACT_UNSIGNED, MOST_NEG, 2);
    send_word(ACT_UNSIGNED, ALL_ONES, MOST_NEG);
    send_word(ACT_UNSIGNED, 32'h1234_5678, 32'h0000_1234);
    send_word(ACT_SIGNED, MOST_NEG, ALL_ONES);
    send_word(ACT_SIGNED, MOST_NEG, 1);
    send_word(ACT_SIGNED, MOST_NEG, MOST_NEG);
    send_word(ACT_SIGNED, '0 - 32'd7, 2);
    send_word(ACT_SIGNED, 7, '0 - 32'd2);
    send_word(ACT_SIGNED, '0 - 32'd7, '0 - 32'd2);
    send_word(ACT_SIGNED, MOST_POS, ALL_ONES);
    send_word(ACT_SIGNED, 5, '0);
    send_word(ACT_SIGNED, ALL_ONES, '0);
    send_word(ACT_SIGNED, '0, ALL_ONES);
    send_word(ACT_SIGNED, 3, 7);
    send_word(ACT_SIGNED, MOST_POS, MOST_NEG);

    // slow receiver, with a long hold-off while words keep coming
    send_random(ITEMS_PER_PHASE, 100, -1);

    // slow sender, with a pause until the block is empty
    send_idle_pct = 68;
    recv_idle_pct = 30;
    send_random(ITEMS_PER_PHASE, -1, 150);

    // back to back
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(ITEMS_PER_PHASE, -1, -1);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/issd_pkg.sv
sv/issd_cell.sv
sv/issd_array.sv
sv/int32_shift_subtract_divider_unit.sv
tb/int32_shift_subtract_divider_unit_chk.sv
tb/int32_shift_subtract_divider_unit_tb.sv
